FILE: sv/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types, constants and small tables for the Gregorian date pipeline.
// ----------------------------------------------------------------------------
package gda_pkg;

  // Pipeline depths of the two converters
  localparam int unsigned LAT_JDN   = 4;
  localparam int unsigned LAT_CIVIL = 9;

  // Date used in place of an invalid one
  localparam logic [3:0]  DEF_MONTH = 4'd5;
  localparam logic [4:0]  DEF_DAY   = 5'd11;
  localparam logic [13:0] DEF_YEAR  = 14'd1959;

  // Day numbers of 1 January 1 and 31 December 9999
  localparam logic [22:0] JDN_MIN = 23'd1721426;
  localparam logic [22:0] JDN_MAX = 23'd5373484;

  // Validated date and its day number
  typedef struct packed {
    logic        ok;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [13:0] year;
    logic [22:0] jdn;
  } jdn_res_t;

  // Calendar date rebuilt from a day number
  typedef struct packed {
    logic [3:0]  month;
    logic [4:0]  day;
    logic [13:0] year;
  } civil_res_t;

  // Fields that ride alongside the day-number-to-date pipeline
  typedef struct packed {
    logic        ok1;
    logic        ok2;
    logic [22:0] jdn;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [13:0] year;
    logic        ovf;
    logic [22:0] diff;
    logic [2:0]  wd;
  } side_t;

  // Days in a month
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // 367 * (month - 2 + 12 * early) / 12
  function automatic logic [8:0] month_term(input logic [3:0] month);
    logic [8:0] t;
    case (month)
      4'd1:    t = 9'd336;
      4'd2:    t = 9'd367;
      4'd3:    t = 9'd30;
      4'd4:    t = 9'd61;
      4'd5:    t = 9'd91;
      4'd6:    t = 9'd122;
      4'd7:    t = 9'd152;
      4'd8:    t = 9'd183;
      4'd9:    t = 9'd214;
      4'd10:   t = 9'd244;
      4'd11:   t = 9'd275;
      4'd12:   t = 9'd305;
      default: t = 9'd0;
    endcase
    return t;
  endfunction

  // 2447 * j / 80, the day offset where shifted month j begins
  function automatic logic [8:0] day_base(input logic [3:0] j);
    logic [8:0] b;
    case (j)
      4'd0:    b = 9'd0;
      4'd1:    b = 9'd30;
      4'd2:    b = 9'd61;
      4'd3:    b = 9'd91;
      4'd4:    b = 9'd122;
      4'd5:    b = 9'd152;
      4'd6:    b = 9'd183;
      4'd7:    b = 9'd214;
      4'd8:    b = 9'd244;
      4'd9:    b = 9'd275;
      4'd10:   b = 9'd305;
      4'd11:   b = 9'd336;
      4'd12:   b = 9'd367;
      4'd13:   b = 9'd397;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

endpackage

FILE: sv/gda_jdn.sv
// ----------------------------------------------------------------------------
// gda_jdn
// Validates one date, substitutes the default date, and converts it to its
// Julian day number over four register stages.
// ----------------------------------------------------------------------------
module gda_jdn (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [3:0]           month,
  input  logic [4:0]           day,
  input  logic [13:0]          year,
  output logic                 out_valid,
  output gda_pkg::jdn_res_t    result
);

  // Stage A: capture the date, divide the year by 100
  logic        a_valid;
  logic [3:0]  a_month;
  logic [4:0]  a_day;
  logic [13:0] a_year;
  logic [7:0]  a_cent;
  logic [26:0] cent_prod;

  assign cent_prod = 27'(year) * 27'd5243;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_month <= month;
    a_day   <= day;
    a_year  <= year;
    a_cent  <= cent_prod[26:19];
  end

  // Stage B: leap rule, range checks, default substitution
  logic        leap;
  logic        date_ok;
  logic [14:0] cent_x100;
  logic [3:0]  sel_month;
  logic [4:0]  sel_day;
  logic [13:0] sel_year;
  logic        early;

  always_comb begin
    cent_x100 = 15'(a_cent) * 15'd100;
    leap = (a_year[1:0] == 2'b00) &&
           (({1'b0, a_year} != cent_x100) || (a_cent[1:0] == 2'b00));
    date_ok = (a_year >= 14'd1) && (a_year <= 14'd9999) &&
              (a_month >= 4'd1) && (a_month <= 4'd12) &&
              (a_day >= 5'd1) && (a_day <= gda_pkg::month_len(a_month, leap));
    sel_month = date_ok ? a_month : gda_pkg::DEF_MONTH;
    sel_day   = date_ok ? a_day   : gda_pkg::DEF_DAY;
    sel_year  = date_ok ? a_year  : gda_pkg::DEF_YEAR;
    early     = (sel_month <= 4'd2);
  end

  logic        b_valid;
  logic        b_ok;
  logic [3:0]  b_month;
  logic [4:0]  b_day;
  logic [13:0] b_year;
  logic [13:0] b_yp;
  logic [13:0] b_yc;
  logic [8:0]  b_mt;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_ok    <= date_ok;
    b_month <= sel_month;
    b_day   <= sel_day;
    b_year  <= sel_year;
    b_yp    <= sel_year + 14'd4800 - 14'(early);
    b_yc    <= sel_year + 14'd4900 - 14'(early);
    b_mt    <= gda_pkg::month_term(sel_month);
  end

  // Stage C: century count and the year, month and day terms
  logic [26:0] yc_prod;
  logic [23:0] part_sum;

  always_comb begin
    yc_prod  = 27'(b_yc) * 27'd5243;
    part_sum = 24'(b_yp) * 24'd365 + 24'(b_yp >> 2) + 24'(b_day) + 24'(b_mt) -
               24'd32075;
  end

  logic        c_valid;
  logic        c_ok;
  logic [3:0]  c_month;
  logic [4:0]  c_day;
  logic [13:0] c_year;
  logic [7:0]  c_cent;
  logic [23:0] c_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
    c_ok    <= b_ok;
    c_month <= b_month;
    c_day   <= b_day;
    c_year  <= b_year;
    c_cent  <= yc_prod[26:19];
    c_sum   <= part_sum;
  end

  // Stage D: drop the century correction
  logic [9:0]  cent_x3;
  logic [23:0] jdn_full;

  always_comb begin
    cent_x3  = 10'(c_cent) * 10'd3;
    jdn_full = c_sum - 24'(cent_x3[9:2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= c_valid;
    end
    result.ok    <= c_ok;
    result.month <= c_month;
    result.day   <= c_day;
    result.year  <= c_year;
    result.jdn   <= jdn_full[22:0];
  end

endmodule

FILE: sv/gda_civil.sv
// ----------------------------------------------------------------------------
// gda_civil
// Converts a Julian day number back to a Gregorian date over nine register
// stages; both wide divisions are reciprocal estimates with one correction.
// ----------------------------------------------------------------------------
module gda_civil (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [22:0]           jdn,
  output logic                  out_valid,
  output gda_pkg::civil_res_t   result
);

  logic [gda_pkg::LAT_CIVIL-2:0] vld;

  // Advance the valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[gda_pkg::LAT_CIVIL-3:0], in_valid};
      out_valid <= vld[gda_pkg::LAT_CIVIL-2];
    end
  end

  // Stage 1: shift the day number, estimate 4l / 146097
  logic [22:0] l0;
  logic [32:0] n_prod;
  logic [22:0] s1_l;
  logic [7:0]  s1_n0;

  always_comb begin
    l0     = jdn + 23'd68569;
    n_prod = 33'({l0, 2'b00}) * 33'd229;
  end

  always_ff @(posedge clk) begin
    s1_l  <= l0;
    s1_n0 <= n_prod[32:25];
  end

  // Stage 2: correct the 400-year count
  logic [25:0] n_rem;
  logic [22:0] s2_l;
  logic [7:0]  s2_n;

  assign n_rem = 26'({s1_l, 2'b00}) - 26'(s1_n0) * 26'd146097;

  always_ff @(posedge clk) begin
    s2_l <= s1_l;
    s2_n <= s1_n0 + 8'(n_rem >= 26'd146097);
  end

  // Stage 3: days within the 400-year cycle
  logic [25:0] cyc_days;
  logic [22:0] l2_full;
  logic [16:0] s3_l2;
  logic [7:0]  s3_n;

  always_comb begin
    cyc_days = (26'(s2_n) * 26'd146097 + 26'd3) >> 2;
    l2_full  = s2_l - cyc_days[22:0];
  end

  always_ff @(posedge clk) begin
    s3_l2 <= l2_full[16:0];
    s3_n  <= s2_n;
  end

  // Stage 4: scale for the year-in-cycle division
  logic [28:0] s4_x;
  logic [16:0] s4_l2;
  logic [7:0]  s4_n;

  always_ff @(posedge clk) begin
    s4_x  <= (29'(s3_l2) + 29'd1) * 29'd4000;
    s4_l2 <= s3_l2;
    s4_n  <= s3_n;
  end

  // Stage 5: estimate x / 1461001
  logic [36:0] i_prod;
  logic [8:0]  s5_i0;
  logic [28:0] s5_x;
  logic [16:0] s5_l2;
  logic [7:0]  s5_n;

  assign i_prod = 37'(s4_x) * 37'd183;

  always_ff @(posedge clk) begin
    s5_i0 <= i_prod[36:28];
    s5_x  <= s4_x;
    s5_l2 <= s4_l2;
    s5_n  <= s4_n;
  end

  // Stage 6: correct the year in cycle
  logic [29:0] i_rem;
  logic [8:0]  s6_i;
  logic [16:0] s6_l2;
  logic [7:0]  s6_n;

  assign i_rem = 30'(s5_x) - 30'(s5_i0) * 30'd1461001;

  always_ff @(posedge clk) begin
    s6_i  <= s5_i0 + 9'(i_rem >= 30'd1461001);
    s6_l2 <= s5_l2;
    s6_n  <= s5_n;
  end

  // Stage 7: day within the shifted year
  logic [17:0] l3_full;
  logic [17:0] yr_days;
  logic [9:0]  s7_l3;
  logic [8:0]  s7_i;
  logic [7:0]  s7_n;

  always_comb begin
    yr_days = (18'(s6_i) * 18'd1461) >> 2;
    l3_full = 18'(s6_l2) - yr_days + 18'd31;
  end

  always_ff @(posedge clk) begin
    s7_l3 <= l3_full[9:0];
    s7_i  <= s6_i;
    s7_n  <= s6_n;
  end

  // Stage 8: month index by comparing against each month start
  logic [3:0]  j_cnt;
  logic [3:0]  s8_j;
  logic [9:0]  s8_l3;
  logic [8:0]  s8_i;
  logic [7:0]  s8_n;

  always_comb begin
    j_cnt = 4'd0;
    for (int k = 1; k <= 13; k++) begin
      if (s7_l3 > 10'(gda_pkg::day_base(4'(k)))) begin
        j_cnt = j_cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s8_j  <= j_cnt;
    s8_l3 <= s7_l3;
    s8_i  <= s7_i;
    s8_n  <= s7_n;
  end

  // Stage 9: assemble day, month and year
  logic        wrap;
  logic [9:0]  day_full;
  logic [15:0] year_full;

  always_comb begin
    wrap      = (s8_j >= 4'd11);
    day_full  = s8_l3 - 10'(gda_pkg::day_base(s8_j));
    year_full = 16'(s8_n) * 16'd100 - 16'd4900 + 16'(s8_i) + 16'(wrap);
  end

  always_ff @(posedge clk) begin
    result.day   <= day_full[4:0];
    result.month <= wrap ? s8_j - 4'd10 : s8_j + 4'd2;
    result.year  <= year_full[13:0];
  end

endmodule

FILE: sv/gregorian_date_arithmetic.sv
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic
// Julian day number, shift and weekday of one date; day difference of two.
// ----------------------------------------------------------------------------
// Usage:
//   Drive both dates and day_offset and raise start; the query transfers at
//   each rising edge where start is high and busy is low. busy is always low,
//   so one query can transfer in every cycle.
//   Each query yields one result, shown for exactly one cycle with done high,
//   after its transfer passes 4 stages of date check and day number, 1 stage
//   of shift, difference and weekday, 9 stages of day number to date, and 1
//   output stage. Throughput is one query per cycle.
//   Invalid dates are replaced by 11 May 1959 with the valid flag low. A shift
//   outside years 1 to 9999 raises shift_overflow and returns the first date.
//   Reset clears all valid bits; queries in flight are dropped and no done
//   follows. The receiver cannot stall, so nothing is ever held back.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         date_month,
  input  logic [4:0]         date_day,
  input  logic [13:0]        date_year,
  input  logic [3:0]         other_month,
  input  logic [4:0]         other_day,
  input  logic [13:0]        other_year,
  input  logic signed [22:0] day_offset,
  output logic               done,
  output logic               first_valid,
  output logic               second_valid,
  output logic [22:0]        day_number,
  output logic [3:0]         shifted_month,
  output logic [4:0]         shifted_day,
  output logic [13:0]        shifted_year,
  output logic               shift_overflow,
  output logic signed [22:0] days_between,
  output logic [2:0]         weekday
);

  localparam int unsigned TOTAL_LAT = gda_pkg::LAT_JDN + gda_pkg::LAT_CIVIL + 2;

  assign busy = 1'b0;

  logic take;
  assign take = start && !busy;

  // Convert both dates
  logic               first_vld;
  logic               second_vld;
  gda_pkg::jdn_res_t  first_res;
  gda_pkg::jdn_res_t  second_res;

  gda_jdn u_first (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (take),
    .month     (date_month),
    .day       (date_day),
    .year      (date_year),
    .out_valid (first_vld),
    .result    (first_res)
  );

  gda_jdn u_second (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (take),
    .month     (other_month),
    .day       (other_day),
    .year      (other_year),
    .out_valid (second_vld),
    .result    (second_res)
  );

  // Hold the offset until the day numbers are ready
  logic signed [22:0] off_dly [gda_pkg::LAT_JDN];

  always_ff @(posedge clk) begin
    off_dly[0] <= day_offset;
    for (int k = 1; k < gda_pkg::LAT_JDN; k++) begin
      off_dly[k] <= off_dly[k-1];
    end
  end

  // Shift, range check, difference and weekday
  logic signed [24:0] js;
  logic               ovf;
  logic [23:0]        jdn_pad;
  logic [5:0]         oct_sum;
  logic [3:0]         fold1;
  logic [3:0]         fold2;
  logic [2:0]         wd;

  always_comb begin
    js  = $signed({2'b00, first_res.jdn}) + 25'(off_dly[gda_pkg::LAT_JDN-1]);
    ovf = (js < $signed({2'b00, gda_pkg::JDN_MIN})) ||
          (js > $signed({2'b00, gda_pkg::JDN_MAX}));
    // 8 is 1 mod 7: fold octal digits
    jdn_pad = {1'b0, first_res.jdn};
    oct_sum = 6'd0;
    for (int k = 0; k < 8; k++) begin
      oct_sum = oct_sum + 6'(jdn_pad[3*k +: 3]);
    end
    fold1 = 4'(oct_sum[5:3]) + 4'(oct_sum[2:0]);
    fold2 = 4'(fold1[3]) + 4'(fold1[2:0]);
    wd    = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
  end

  logic           e_valid;
  logic [22:0]    e_js;
  gda_pkg::side_t e_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= first_vld;
    end
    e_js         <= js[22:0];
    e_side.ok1   <= first_res.ok;
    e_side.ok2   <= second_res.ok;
    e_side.jdn   <= first_res.jdn;
    e_side.month <= first_res.month;
    e_side.day   <= first_res.day;
    e_side.year  <= first_res.year;
    e_side.ovf   <= ovf;
    e_side.diff  <= second_res.jdn - first_res.jdn;
    e_side.wd    <= wd;
  end

  // Day number back to a date
  logic                 civil_vld;
  gda_pkg::civil_res_t  civil_res;

  gda_civil u_civil (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (e_valid),
    .jdn       (e_js),
    .out_valid (civil_vld),
    .result    (civil_res)
  );

  // Carry the other fields alongside
  gda_pkg::side_t side_dly [gda_pkg::LAT_CIVIL];

  always_ff @(posedge clk) begin
    side_dly[0] <= e_side;
    for (int k = 1; k < gda_pkg::LAT_CIVIL; k++) begin
      side_dly[k] <= side_dly[k-1];
    end
  end

  // Output stage
  gda_pkg::side_t side_out;
  assign side_out = side_dly[gda_pkg::LAT_CIVIL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= civil_vld;
    end
    first_valid    <= side_out.ok1;
    second_valid   <= side_out.ok2;
    day_number     <= side_out.jdn;
    shift_overflow <= side_out.ovf;
    days_between   <= side_out.diff;
    weekday        <= side_out.wd;
    shifted_month  <= side_out.ovf ? side_out.month : civil_res.month;
    shifted_day    <= side_out.ovf ? side_out.day   : civil_res.day;
    shifted_year   <= side_out.ovf ? side_out.year  : civil_res.year;
  end

  // Checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    take |-> ##TOTAL_LAT done)
    else $error("result missing after query transfer");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    first_vld == second_vld)
    else $error("date converters out of step");

  a_weekday: assert property (@(posedge clk) disable iff (rst)
    done |-> weekday <= 3'd6)
    else $error("weekday out of range");

  a_shift_date: assert property (@(posedge clk) disable iff (rst)
    done && !shift_overflow |-> (shifted_month >= 4'd1) && (shifted_month <= 4'd12) &&
                                (shifted_day >= 5'd1))
    else $error("shifted date malformed");

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the Gregorian date block: day number, shifted date, day difference
// and weekday. A local calendar predictor computes each expected result at
// transfer time; a monitor compares every done strobe against the oldest one.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        ok1;
    logic        ok2;
    logic [22:0] jdn;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [13:0] year;
    logic        ovf;
    logic [22:0] diff;
    logic [2:0]  wd;
  } date_answer_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [3:0]         date_month = '0;
  logic [4:0]         date_day = '0;
  logic [13:0]        date_year = '0;
  logic [3:0]         other_month = '0;
  logic [4:0]         other_day = '0;
  logic [13:0]        other_year = '0;
  logic signed [22:0] day_offset = '0;
  logic               done;
  logic               first_valid, second_valid, shift_overflow;
  logic [22:0]        day_number;
  logic [3:0]         shifted_month;
  logic [4:0]         shifted_day;
  logic [13:0]        shifted_year;
  logic signed [22:0] days_between;
  logic [2:0]         weekday;

  date_answer_t pending_answers[$];
  int           error_count = 0;
  int           idle_cycles = 0;
  int           burst_left = 0;
  localparam int IDLE_LIMIT = 2000;

  gregorian_date_arithmetic dut (.*);

  always #5 clk = ~clk;

  // Leap-year and month-length checks
  function automatic bit leap_year(longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic bit date_is_valid(longint m, longint d, longint y);
    longint len;
    if (y < 1 || y > 9999 || m < 1 || m > 12 || d < 1) return 0;
    if (m == 2) len = leap_year(y) ? 29 : 28;
    else if (m == 4 || m == 6 || m == 9 || m == 11) len = 30;
    else len = 31;
    return d <= len;
  endfunction

  function automatic longint civil_to_jdn(longint m, longint d, longint y);
    longint a;
    a = (m <= 2) ? 1 : 0;
    return d - 32075 + 1461 * (y + 4800 - a) / 4 + 367 * (m - 2 + 12 * a) / 12
           - 3 * ((y + 4900 - a) / 100) / 4;
  endfunction

  // Predict one full result from the query fields
  function automatic date_answer_t predict_dates(logic [3:0] m1i, logic [4:0] d1i,
      logic [13:0] y1i, logic [3:0] m2i, logic [4:0] d2i, logic [13:0] y2i,
      logic signed [22:0] offi);
    date_answer_t r;
    longint m1, d1, y1, m2, d2, y2, j1, j2, js, l, n, i, j, k;
    m1 = longint'(m1i); d1 = longint'(d1i); y1 = longint'(y1i);
    m2 = longint'(m2i); d2 = longint'(d2i); y2 = longint'(y2i);
    r.ok1 = date_is_valid(m1, d1, y1);
    if (!r.ok1) begin
      m1 = longint'(gda_pkg::DEF_MONTH); d1 = longint'(gda_pkg::DEF_DAY);
      y1 = longint'(gda_pkg::DEF_YEAR);
    end
    r.ok2 = date_is_valid(m2, d2, y2);
    if (!r.ok2) begin
      m2 = longint'(gda_pkg::DEF_MONTH); d2 = longint'(gda_pkg::DEF_DAY);
      y2 = longint'(gda_pkg::DEF_YEAR);
    end
    j1 = civil_to_jdn(m1, d1, y1);
    j2 = civil_to_jdn(m2, d2, y2);
    js = j1 + longint'(offi);
    r.ovf = (js < 1721426 || js > 5373484);
    if (r.ovf) begin
      r.month = 4'(m1); r.day = 5'(d1); r.year = 14'(y1);
    end else begin
      l = js + 68569;
      n = 4 * l / 146097;
      l = l - (146097 * n + 3) / 4;
      i = 4000 * (l + 1) / 1461001;
      l = l - 1461 * i / 4 + 31;
      j = 80 * l / 2447;
      k = l - 2447 * j / 80;
      l = j / 11;
      j = j + 2 - 12 * l;
      r.year = 14'(100 * (n - 49) + i + l);
      r.month = 4'(j);
      r.day = 5'(k);
    end
    r.jdn = 23'(j1);
    r.diff = 23'(j2 - j1);
    r.wd = 3'(j1 % 7);
    return r;
  endfunction

  // Send one query; gaps between random-length bursts
  task automatic send_query(logic [3:0] m1, logic [4:0] d1, logic [13:0] y1,
      logic [3:0] m2, logic [4:0] d2, logic [13:0] y2, logic signed [22:0] off);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    date_month <= m1; date_day <= d1; date_year <= y1;
    other_month <= m2; other_day <= d2; other_year <= y2;
    day_offset <= off;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_answers.push_back(predict_dates(m1, d1, y1, m2, d2, y2, off));
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Extremes, leap rules, invalid dates and shift limits
  task automatic test_directed();
    send_query(1, 1, 1, 12, 31, 9999, 0);
    send_query(12, 31, 9999, 1, 1, 1, 0);
    send_query(2, 29, 2000, 2, 29, 2004, 1);
    send_query(2, 29, 1900, 2, 29, 2001, 0);
    send_query(2, 30, 2000, 2, 31, 2000, 0);
    send_query(0, 10, 2020, 13, 10, 2020, 5);
    send_query(15, 31, 16383, 4, 31, 2020, -5);
    send_query(6, 0, 0, 6, 31, 0, 0);
    send_query(1, 1, 1, 1, 1, 1, -1);
    send_query(12, 31, 9999, 3, 1, 2000, 1);
    send_query(3, 15, 2000, 3, 15, 2000, 23'sh3FFFFF);
    send_query(3, 15, 2000, 3, 15, 2000, 23'sh400000);
    send_query(1, 1, 1, 6, 1, 5000, 3652058);
    send_query(12, 31, 9999, 6, 1, 5000, -3652058);
    send_query(5, 11, 1959, 7, 4, 1776, -1);
    hold_until_drained();
  endtask

  // Mostly valid dates with random content, some noise
  task automatic test_random(int count);
    logic [3:0] m1, m2;
    logic [4:0] d1, d2;
    logic [13:0] y1, y2;
    logic signed [22:0] off;
    for (int n = 0; n < count; n++) begin
      m1 = 4'($urandom_range(1, 12)); d1 = 5'($urandom_range(1, 28));
      y1 = 14'($urandom_range(1, 9999));
      m2 = 4'($urandom_range(1, 12)); d2 = 5'($urandom_range(1, 31));
      y2 = 14'($urandom_range(1, 9999));
      if ($urandom_range(0, 9) == 0) begin
        m1 = 4'($urandom); d1 = 5'($urandom); y1 = 14'($urandom);
      end
      if ($urandom_range(0, 9) == 0) begin
        m2 = 4'($urandom); d2 = 5'($urandom); y2 = 14'($urandom);
      end
      if ($urandom_range(0, 3) == 0) d1 = 5'($urandom_range(29, 31));
      case ($urandom_range(0, 3))
        0: off = 23'($urandom_range(0, 2000) - 1000);
        1: off = 23'($urandom_range(0, 400000) - 200000);
        default: off = 23'($urandom);
      endcase
      send_query(m1, d1, y1, m2, d2, y2, off);
      if (n == count / 2) hold_until_drained();
    end
  endtask

  // Compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    date_answer_t e;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $error("result with nothing expected");
        error_count++;
      end else begin
        e = pending_answers.pop_front();
        if (first_valid !== e.ok1) begin
          $error("first_valid exp %0d got %0d", e.ok1, first_valid); error_count++;
        end
        if (second_valid !== e.ok2) begin
          $error("second_valid exp %0d got %0d", e.ok2, second_valid); error_count++;
        end
        if (day_number !== e.jdn) begin
          $error("day_number exp %0d got %0d", e.jdn, day_number); error_count++;
        end
        if (shifted_month !== e.month) begin
          $error("shifted_month exp %0d got %0d", e.month, shifted_month); error_count++;
        end
        if (shifted_day !== e.day) begin
          $error("shifted_day exp %0d got %0d", e.day, shifted_day); error_count++;
        end
        if (shifted_year !== e.year) begin
          $error("shifted_year exp %0d got %0d", e.year, shifted_year); error_count++;
        end
        if (shift_overflow !== e.ovf) begin
          $error("shift_overflow exp %0d got %0d", e.ovf, shift_overflow); error_count++;
        end
        if (days_between !== e.diff) begin
          $error("days_between exp %0d got %0d", $signed(e.diff), days_between);
          error_count++;
        end
        if (weekday !== e.wd) begin
          $error("weekday exp %0d got %0d", e.wd, weekday); error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(2000);
    hold_until_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
